// ----- src/emv_pkg.sv -----
// ----------------------------------------------------------------------------
// emv_pkg: shared types and constants
// Field widths, register reset values, register indexes, wrap codes and the
// configuration bundle used by the multiturn encoder block.
// ----------------------------------------------------------------------------
package emv_pkg;

  // Default geometry
  localparam int ANGLE_BITS_DEF = 14;
  localparam int TURN_BITS_DEF  = 32;

  // Port field widths
  localparam int RAW_W   = 16;
  localparam int SHAFT_W = 14;
  localparam int TURNS_W = 32;
  localparam int TOTAL_W = 46;
  localparam int ELEC_W  = 18;
  localparam int VEL_W   = 31;

  // Configuration register widths
  localparam int PP_W   = 4;
  localparam int RATE_W = 16;
  localparam int THR_W  = 14;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;

  // Clamped position change feeding the velocity multiply (+-2^32)
  localparam int DPOS_W = 34;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ELEC_MULT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [PP_W-1:0]   ELEC_MULT_RST      = 4'd7;
  localparam logic [RATE_W-1:0] SAMPLE_RATE_RST    = 16'd1000;
  localparam logic [THR_W-1:0]  WRAP_THRESHOLD_RST = 14'd13107;

  // Turn counter move decided by the front end
  typedef enum logic [1:0] {
    WRAP_NONE = 2'b00,
    WRAP_FWD  = 2'b01,
    WRAP_BACK = 2'b10
  } wrap_t;

  typedef struct packed {
    logic [PP_W-1:0]   elec_mult;
    logic [RATE_W-1:0] sample_rate;
    logic [THR_W-1:0]  wrap_threshold;
  } cfg_t;

endpackage

// ----- src/emv_ifs.sv -----
// ----------------------------------------------------------------------------
// emv_ifs: request channels
// Valid/ready channels for sensor samples and for position/velocity results.
// ----------------------------------------------------------------------------
interface emv_in_if;
  logic                      valid;
  logic                      ready;
  logic [emv_pkg::RAW_W-1:0] raw_word;
  logic                      read_ok;

  modport source (output valid, raw_word, read_ok, input ready);
  modport sink   (input valid, raw_word, read_ok, output ready);
endinterface

interface emv_out_if;
  logic                               valid;
  logic                               ready;
  logic [emv_pkg::SHAFT_W-1:0]        shaft_angle;
  logic signed [emv_pkg::TURNS_W-1:0] turns;
  logic signed [emv_pkg::TOTAL_W-1:0] total_position;
  logic [emv_pkg::ELEC_W-1:0]         electrical_angle;
  logic signed [emv_pkg::VEL_W-1:0]   velocity;

  modport source (output valid, shaft_angle, turns, total_position, electrical_angle,
                  velocity, input ready);
  modport sink   (input valid, shaft_angle, turns, total_position, electrical_angle,
                  velocity, output ready);
endinterface

// ----- src/emv_front.sv -----
// ----------------------------------------------------------------------------
// emv_front: sample intake and wrap detection
// Extracts the shaft angle, compares it with the previous angle and tags the
// request with the turn counter move.
// ----------------------------------------------------------------------------
module emv_front #(
  parameter int ANGLE_BITS = emv_pkg::ANGLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [emv_pkg::RAW_W-1:0]   raw_word,
  input  logic                        read_ok,
  input  logic [emv_pkg::THR_W-1:0]   wrap_threshold,
  input  logic                        q_full,
  output logic                        push,
  output logic [ANGLE_BITS+1:0]       push_data
);

  localparam int MW = (ANGLE_BITS + 1 > emv_pkg::THR_W + 1) ? ANGLE_BITS + 1
                                                            : emv_pkg::THR_W + 1;

  logic [ANGLE_BITS-1:0] last_angle_r;
  logic [ANGLE_BITS-1:0] angle;
  logic signed [MW-1:0]  delta;
  logic signed [MW-1:0]  mag;
  logic                  wrap;
  emv_pkg::wrap_t        dir;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  assign angle = read_ok ? raw_word[emv_pkg::RAW_W-1 -: ANGLE_BITS] : '0;
  assign delta = $signed(MW'(angle)) - $signed(MW'(last_angle_r));
  assign mag   = delta[MW-1] ? -delta : delta;
  assign wrap  = mag > $signed(MW'(wrap_threshold));

  // A large backward jump means the shaft crossed zero going forward
  always_comb begin
    if (!wrap) begin
      dir = emv_pkg::WRAP_NONE;
    end else if (delta[MW-1]) begin
      dir = emv_pkg::WRAP_FWD;
    end else begin
      dir = emv_pkg::WRAP_BACK;
    end
  end

  assign push_data = {dir, angle};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_angle_r <= '0;
    end else if (push) begin
      last_angle_r <= angle;
    end
  end

endmodule

// ----- src/emv_queue.sv -----
// ----------------------------------------------------------------------------
// emv_queue: two-entry request queue
// Decouples the intake from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module emv_queue #(
  parameter int W = emv_pkg::ANGLE_BITS_DEF + 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         valid,
  output logic [W-1:0] data,
  input  logic         pop
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;
  logic [1:0]   count_nxt;

  assign full  = count_r == 2'd2;
  assign valid = count_r != 2'd0;
  assign data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ----- src/emv_back.sv -----
// ----------------------------------------------------------------------------
// emv_back: position and velocity pipeline
// Three stages: turn update and total, position change with clamp, velocity
// multiply with saturation into the output register.
// ----------------------------------------------------------------------------
module emv_back #(
  parameter int ANGLE_BITS = emv_pkg::ANGLE_BITS_DEF,
  parameter int TURN_BITS  = emv_pkg::TURN_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  emv_pkg::cfg_t                      cfg,
  input  logic                               q_valid,
  input  logic [ANGLE_BITS+1:0]              q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [emv_pkg::SHAFT_W-1:0]        shaft_angle,
  output logic signed [emv_pkg::TURNS_W-1:0] turns,
  output logic signed [emv_pkg::TOTAL_W-1:0] total_position,
  output logic [emv_pkg::ELEC_W-1:0]         electrical_angle,
  output logic signed [emv_pkg::VEL_W-1:0]   velocity
);

  localparam int TOT_W = TURN_BITS + ANGLE_BITS;
  localparam int DW    = (TOT_W + 1 > emv_pkg::DPOS_W) ? TOT_W + 1 : emv_pkg::DPOS_W;
  localparam int EW    = ANGLE_BITS + emv_pkg::PP_W;
  localparam int PW    = emv_pkg::DPOS_W + emv_pkg::RATE_W + 1;

  localparam logic signed [TURN_BITS-1:0] T_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] T_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};
  localparam logic signed [DW-1:0] DP_HI = DW'(64'sh1_0000_0000);
  localparam logic signed [DW-1:0] DP_LO = -DP_HI;
  localparam logic signed [PW-1:0] V_HI  = PW'({1'b0, {(emv_pkg::VEL_W-1){1'b1}}});
  localparam logic signed [PW-1:0] V_LO  = -V_HI - PW'(1);

  // Stage enables: advance when the stage ahead is empty or moving
  logic en1, en2, en3;

  logic [ANGLE_BITS-1:0]       q_angle;
  emv_pkg::wrap_t              q_dir;
  logic signed [TURN_BITS-1:0] turn_r;
  logic signed [TURN_BITS-1:0] turn_nxt;
  logic signed [TOT_W-1:0]     total_nxt;
  logic [EW-1:0]               elec_nxt;

  logic                        v1_r;
  logic [ANGLE_BITS-1:0]       ang1_r;
  logic signed [TURN_BITS-1:0] turn1_r;
  logic signed [TOT_W-1:0]     total1_r;
  logic [EW-1:0]               elec1_r;

  logic signed [TOT_W-1:0]     last_total_r;
  logic signed [DW-1:0]        dpos;
  logic signed [DW-1:0]        dpos_clamp;

  logic                        v2_r;
  logic [ANGLE_BITS-1:0]       ang2_r;
  logic signed [TURN_BITS-1:0] turn2_r;
  logic signed [TOT_W-1:0]     total2_r;
  logic [EW-1:0]               elec2_r;
  logic signed [emv_pkg::DPOS_W-1:0] dpos2_r;

  logic signed [PW-1:0]        prod;
  logic signed [PW-1:0]        vel_sat;

  logic                              ov_r;
  logic [ANGLE_BITS+emv_pkg::SHAFT_W-1:0] shaft_ext;
  logic [EW+emv_pkg::ELEC_W-1:0]     elec_ext;
  logic signed [emv_pkg::TOTAL_W+2-1:0] total_ext;
  logic [emv_pkg::SHAFT_W-1:0]       shaft_r;
  logic signed [emv_pkg::TURNS_W-1:0] turns_r;
  logic signed [emv_pkg::TOTAL_W-1:0] total_r;
  logic [emv_pkg::ELEC_W-1:0]        elec_r;
  logic signed [emv_pkg::VEL_W-1:0]  vel_r;

  assign en3   = !ov_r || out_ready;
  assign en2   = !v2_r || en3;
  assign en1   = !v1_r || en2;
  assign q_pop = q_valid && en1;

  assign q_angle = q_data[ANGLE_BITS-1:0];
  assign q_dir   = emv_pkg::wrap_t'(q_data[ANGLE_BITS+1:ANGLE_BITS]);

  // Saturating turn counter
  always_comb begin
    turn_nxt = turn_r;
    unique case (q_dir)
      emv_pkg::WRAP_FWD: begin
        if (turn_r != T_MAX) begin
          turn_nxt = turn_r + TURN_BITS'(1);
        end
      end
      emv_pkg::WRAP_BACK: begin
        if (turn_r != T_MIN) begin
          turn_nxt = turn_r - TURN_BITS'(1);
        end
      end
      default: begin
        turn_nxt = turn_r;
      end
    endcase
  end

  assign total_nxt = $signed({turn_nxt, q_angle});
  assign elec_nxt  = EW'(q_angle) * EW'(cfg.elec_mult);

  // Stage 1: turn count, total position, electrical angle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      turn_r <= '0;
    end else begin
      if (en1) begin
        v1_r <= q_valid;
      end
      if (q_pop) begin
        turn_r <= turn_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ang1_r   <= q_angle;
      turn1_r  <= turn_nxt;
      total1_r <= total_nxt;
      elec1_r  <= elec_nxt;
    end
  end

  // Stage 2: position change against the previous total, clamped to +-2^32
  assign dpos = DW'(total1_r) - DW'(last_total_r);

  always_comb begin
    if (dpos > DP_HI) begin
      dpos_clamp = DP_HI;
    end else if (dpos < DP_LO) begin
      dpos_clamp = DP_LO;
    end else begin
      dpos_clamp = dpos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r         <= 1'b0;
      last_total_r <= '0;
    end else begin
      if (en2) begin
        v2_r <= v1_r;
      end
      if (v1_r && en2) begin
        last_total_r <= total1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r && en2) begin
      ang2_r   <= ang1_r;
      turn2_r  <= turn1_r;
      total2_r <= total1_r;
      elec2_r  <= elec1_r;
      dpos2_r  <= dpos_clamp[emv_pkg::DPOS_W-1:0];
    end
  end

  // Stage 3: velocity multiply and saturate, format output fields
  assign prod = dpos2_r * $signed({1'b0, cfg.sample_rate});

  always_comb begin
    if (prod > V_HI) begin
      vel_sat = V_HI;
    end else if (prod < V_LO) begin
      vel_sat = V_LO;
    end else begin
      vel_sat = prod;
    end
  end

  assign shaft_ext = {{emv_pkg::SHAFT_W{1'b0}}, ang2_r};
  assign elec_ext  = {{emv_pkg::ELEC_W{1'b0}}, elec2_r};
  assign total_ext = (emv_pkg::TOTAL_W + 2)'(total2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en3) begin
      ov_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r && en3) begin
      shaft_r <= shaft_ext[emv_pkg::SHAFT_W-1:0];
      turns_r <= emv_pkg::TURNS_W'(turn2_r);
      total_r <= total_ext[emv_pkg::TOTAL_W-1:0];
      elec_r  <= elec_ext[emv_pkg::ELEC_W-1:0];
      vel_r   <= vel_sat[emv_pkg::VEL_W-1:0];
    end
  end

  assign out_valid        = ov_r;
  assign shaft_angle      = shaft_r;
  assign turns            = turns_r;
  assign total_position   = total_r;
  assign electrical_angle = elec_r;
  assign velocity         = vel_r;

endmodule

// ----- src/encoder_multiturn_velocity.sv -----
// ----------------------------------------------------------------------------
// encoder_multiturn_velocity: multiturn position and velocity from an
// absolute angle sensor
// Takes raw sensor words, tracks full turns across the zero crossing and
// reports angle, turns, total position, electrical angle and velocity.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+------------------------------------
//   in_ch   | sink      | valid / ready    | raw_word, read_ok
//   out_ch  | source    | valid / ready    | shaft_angle, turns, total_position,
//           |           |                  | electrical_angle, velocity
//   cfg_*   | sink      | cfg_we (no wait) | cfg_index, cfg_wdata
//
// One request per cycle sustained while out_ch does not stall. A request is
// classified in the intake in the cycle it is accepted, is held in a
// two-entry queue and then passes three arithmetic stages (turn update,
// clamped position change, velocity multiply) before its result is offered.
// The velocity multiplier sets the stage depth.
// Synchronous active-low reset clears turns, last angle, last total and all
// valid flags; registers return to their reset values. When out_ch stalls the
// pipeline fills its bubbles first, then the queue, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module encoder_multiturn_velocity #(
  parameter int ANGLE_BITS = emv_pkg::ANGLE_BITS_DEF,
  parameter int TURN_BITS  = emv_pkg::TURN_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  emv_in_if.sink                            in_ch,
  emv_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [emv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [emv_pkg::CFG_W-1:0]         cfg_wdata
);

  emv_pkg::cfg_t         cfg_r;
  logic                  push;
  logic [ANGLE_BITS+1:0] push_data;
  logic                  q_full;
  logic                  q_valid;
  logic [ANGLE_BITS+1:0] q_data;
  logic                  q_pop;

  // Configuration registers; writes to an unused index are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.elec_mult      <= emv_pkg::ELEC_MULT_RST;
      cfg_r.sample_rate    <= emv_pkg::SAMPLE_RATE_RST;
      cfg_r.wrap_threshold <= emv_pkg::WRAP_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        emv_pkg::REG_ELEC_MULT: begin
          cfg_r.elec_mult <= cfg_wdata[emv_pkg::PP_W-1:0];
        end
        emv_pkg::REG_SAMPLE_RATE: begin
          cfg_r.sample_rate <= cfg_wdata[emv_pkg::RATE_W-1:0];
        end
        emv_pkg::REG_WRAP_THRESHOLD: begin
          cfg_r.wrap_threshold <= cfg_wdata[emv_pkg::THR_W-1:0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Intake: extract angle and classify the turn crossing
  emv_front #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .raw_word       (in_ch.raw_word),
    .read_ok        (in_ch.read_ok),
    .wrap_threshold (cfg_r.wrap_threshold),
    .q_full         (q_full),
    .push           (push),
    .push_data      (push_data)
  );

  // Hold classified requests so intake and arithmetic stall independently
  emv_queue #(
    .W (ANGLE_BITS + 2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .valid     (q_valid),
    .data      (q_data),
    .pop       (q_pop)
  );

  // Arithmetic: turns, total, electrical angle, velocity
  emv_back #(
    .ANGLE_BITS (ANGLE_BITS),
    .TURN_BITS  (TURN_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .shaft_angle      (out_ch.shaft_angle),
    .turns            (out_ch.turns),
    .total_position   (out_ch.total_position),
    .electrical_angle (out_ch.electrical_angle),
    .velocity         (out_ch.velocity)
  );

endmodule
